>>> hw/rtl/spq_pkg.sv
package spq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                    insert;
		logic                    pop;
		logic signed [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/spq_cell.sv
module spq_cell
	import spq_pkg::*;
#(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic [CNT_W-1:0]        count,
	input  logic signed [VAL_W-1:0] left_val,
	input  logic                    left_keep,
	input  logic signed [VAL_W-1:0] right_val,
	output logic signed [VAL_W-1:0] val,
	output logic                    keep
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [VAL_W-1:0] val_q;
	logic                    occupied;

	assign occupied = count > IDX_C;
	// A stored value smaller than the new one stays where it is.
	assign keep     = occupied && (val_q < ctrl.value);
	assign val      = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keep) begin
				val_q <= left_keep ? ctrl.value : left_val;
			end
		end else if (ctrl.pop) begin
			val_q <= right_val;
		end
	end

endmodule

>>> hw/rtl/sorted_list_priority_queue.sv
// Sorted-list priority queue for up to DEPTH signed 32-bit values.
// Input channel s_*: s_tuser carries the command (0 insert, 1 remove
// smallest) and s_tdata the value to insert. Every input transfer gives
// exactly one output transfer on m_*: m_tdata holds the removed value
// (zero when nothing was removed) and the entry count after the item,
// m_tuser holds the popped-valid, overflow and empty flags.
// Values live in a row of cells, one per slot, kept in ascending order.
// On an insert every cell compares itself with the new value at once and
// either holds, takes the new value or takes its left neighbour's value;
// on a remove every cell takes its right neighbour's value.
// An item is processed in the cycle it is accepted, so its result appears
// in the cycle after, and one item per cycle is sustained while results are taken.
// The result sits in an output register; a new item is accepted whenever
// that register is empty or is being taken in the same cycle, so a
// stalled receiver stops the input only once a result is waiting.
// Reset empties the queue and the output register; slot contents are not
// cleared and are only read once written.
module sorted_list_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic        s_tuser,  // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // popped_value[31:0], entry_count[36:32], zeros[39:37]
	output logic [2:0]  m_tuser   // popped_valid[0], overflow[1], is_empty[2]
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

	logic [CNT_W-1:0]        count_q;
	logic                    accept;
	logic                    full;
	logic                    empty;
	cmd_t                    cmd;
	cell_ctrl_t              ctrl;
	logic signed [VAL_W-1:0] cell_val  [DEPTH];
	logic                    cell_keep [DEPTH];

	logic                    m_tvalid_q;
	logic signed [VAL_W-1:0] popped_q;
	logic                    pvalid_q;
	logic                    ovf_q;
	logic [CNT_W-1:0]        cnt_res_q;
	logic [31:0]             cnt_ext;

	assign cmd      = cmd_t'(s_tuser);
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == FULL_C;
	assign empty    = count_q == '0;

	assign ctrl.insert = accept && (cmd == CMD_INSERT) && !full;
	assign ctrl.pop    = accept && (cmd == CMD_POP) && !empty;
	assign ctrl.value  = $signed(s_tdata);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic                    lk;
		logic signed [VAL_W-1:0] rv;
		if (i == 0) begin : g_first
			assign lv = ctrl.value;
			assign lk = 1'b1;
		end else begin : g_mid
			assign lv = cell_val[i-1];
			assign lk = cell_keep[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign rv = '0;
		end else begin : g_inner
			assign rv = cell_val[i+1];
		end
		spq_cell #(
			.CNT_W(CNT_W),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (count_q),
			.left_val (lv),
			.left_keep(lk),
			.right_val(rv),
			.val      (cell_val[i]),
			.keep     (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.insert) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q  <= ctrl.pop ? cell_val[0] : '0;
			pvalid_q  <= ctrl.pop;
			ovf_q     <= (cmd == CMD_INSERT) && full;
			if (ctrl.insert) begin
				cnt_res_q <= count_q + 1'b1;
			end else if (ctrl.pop) begin
				cnt_res_q <= count_q - 1'b1;
			end else begin
				cnt_res_q <= count_q;
			end
		end
	end

	assign cnt_ext  = 32'(cnt_res_q);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, cnt_ext[CNT_OUT_W-1:0], popped_q};
	assign m_tuser  = {(cnt_res_q == '0), ovf_q, pvalid_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("entry count exceeds depth");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> (count_q == $past(count_q) - 1'b1) && m_tuser[0])
		else $error("remove did not shrink the queue");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_INSERT) && full) |=> $stable(count_q) && m_tuser[1])
		else $error("insert into full queue not flagged");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

endmodule
